@@ rtl/core/ps2mpt_pkg.sv @@
package ps2mpt_pkg;

  // Configuration register width and indexes
  localparam int CfgW = 14;
  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  // Reset sizes, before limiting to the coordinate range
  localparam int ResetWidth  = 640;
  localparam int ResetHeight = 480;

  // Header byte bit positions
  localparam int HdrSyncBit  = 3;
  localparam int HdrXSignBit = 4;
  localparam int HdrYSignBit = 5;
  localparam int HdrXOvfBit  = 6;
  localparam int HdrYOvfBit  = 7;

  localparam int MoveXW = 9;
  localparam int MoveYW = 10;
  localparam int BtnW   = 3;

  typedef enum logic [1:0] {
    BpHeader = 2'd0,
    BpX      = 2'd1,
    BpY      = 2'd2
  } byte_pos_e;

  // Packet handed from the byte assembler to the cursor update
  typedef struct packed {
    logic [BtnW-1:0]   buttons;
    logic [MoveXW-1:0] dx;      // {sign, data byte}, two's complement
    logic [MoveXW-1:0] dy;      // as sent by the mouse, upward positive
  } packet_t;

endpackage

@@ rtl/core/ps2mpt_fifo.sv @@
module ps2mpt_fifo #(
  parameter int Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ps2mpt_pkg::packet_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output ps2mpt_pkg::packet_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ps2mpt_pkg::packet_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule

@@ rtl/core/ps2mpt_front.sv @@
module ps2mpt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                q_full_i,
  output logic                pkt_push_o,
  output ps2mpt_pkg::packet_t pkt_o
);

  ps2mpt_pkg::byte_pos_e state_q, state_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] xb_q, xb_d;
  logic       acc;

  assign acc = push_i && !q_full_i;

  assign pkt_o.buttons = hdr_q[ps2mpt_pkg::BtnW-1:0];
  assign pkt_o.dx      = {hdr_q[ps2mpt_pkg::HdrXSignBit], xb_q};
  assign pkt_o.dy      = {hdr_q[ps2mpt_pkg::HdrYSignBit], rx_byte_i};

  always_comb begin
    state_d    = state_q;
    hdr_d      = hdr_q;
    xb_d       = xb_q;
    pkt_push_o = 1'b0;
    unique case (state_q)
      ps2mpt_pkg::BpHeader: begin
        // bytes without the sync bit cannot start a packet
        if (acc && rx_byte_i[ps2mpt_pkg::HdrSyncBit]) begin
          hdr_d   = rx_byte_i;
          state_d = ps2mpt_pkg::BpX;
        end
      end
      ps2mpt_pkg::BpX: begin
        if (acc) begin
          xb_d    = rx_byte_i;
          state_d = ps2mpt_pkg::BpY;
        end
      end
      ps2mpt_pkg::BpY: begin
        if (acc) begin
          state_d    = ps2mpt_pkg::BpHeader;
          pkt_push_o = !(hdr_q[ps2mpt_pkg::HdrXOvfBit] || hdr_q[ps2mpt_pkg::HdrYOvfBit]);
        end
      end
      default: state_d = ps2mpt_pkg::BpHeader;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ps2mpt_pkg::BpHeader;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    xb_q  <= xb_d;
  end

  a_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && state_q == ps2mpt_pkg::BpHeader && !rx_byte_i[ps2mpt_pkg::HdrSyncBit])
    |=> state_q == ps2mpt_pkg::BpHeader)
    else $error("unsynced byte taken as header");

endmodule

@@ rtl/core/ps2mpt_back.sv @@
module ps2mpt_back #(
  parameter int CoordBits = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pkt_valid_i,
  input  ps2mpt_pkg::packet_t             pkt_i,
  output logic                            pkt_pop_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [ps2mpt_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic [CoordBits-1:0]            cursor_x_o,
  output logic [CoordBits-1:0]            cursor_y_o,
  output logic signed [ps2mpt_pkg::MoveXW-1:0] move_x_o,
  output logic signed [ps2mpt_pkg::MoveYW-1:0] move_y_o,
  output logic [ps2mpt_pkg::BtnW-1:0]     button_bits_o
);

  localparam int LimW = CoordBits + 1;
  localparam int CmpW = (LimW > ps2mpt_pkg::CfgW) ? LimW : ps2mpt_pkg::CfgW;
  localparam int SumW = CoordBits + 2;

  // size 0 acts as 1, anything above 2^CoordBits acts as 2^CoordBits
  function automatic logic [LimW-1:0] eff_limit(input logic [ps2mpt_pkg::CfgW-1:0] size);
    logic [CmpW-1:0] s;
    logic [CmpW-1:0] top;
    s   = CmpW'(size);
    top = CmpW'(1) << CoordBits;
    if (s == '0) begin
      eff_limit = LimW'(1);
    end else if (s > top) begin
      eff_limit = top[LimW-1:0];
    end else begin
      eff_limit = s[LimW-1:0];
    end
  endfunction

  function automatic logic [CoordBits-1:0] clamp_move(input logic [CoordBits-1:0] pos,
                                                     input logic signed [SumW-1:0] d,
                                                     input logic [LimW-1:0] lim);
    logic signed [SumW-1:0] sum;
    logic [LimW-1:0]        lim_m1;
    sum    = $signed({2'b00, pos}) + d;
    lim_m1 = lim - LimW'(1);
    if (sum < 0) begin
      clamp_move = '0;
    end else if (sum >= $signed({1'b0, lim})) begin
      clamp_move = lim_m1[CoordBits-1:0];
    end else begin
      clamp_move = sum[CoordBits-1:0];
    end
  endfunction

  localparam logic [LimW-1:0] ResetLimX = eff_limit(ps2mpt_pkg::CfgW'(ps2mpt_pkg::ResetWidth));
  localparam logic [LimW-1:0] ResetLimY = eff_limit(ps2mpt_pkg::CfgW'(ps2mpt_pkg::ResetHeight));

  logic [LimW-1:0]      lim_x_q, lim_x_d, lim_y_q, lim_y_d;
  logic [CoordBits-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic                 out_valid_q, out_valid_d;
  logic                 load;
  logic signed [ps2mpt_pkg::MoveXW-1:0] dx;
  logic signed [ps2mpt_pkg::MoveYW-1:0] dy_neg;
  logic [CoordBits-1:0] cur_x_q, cur_y_q;
  logic signed [ps2mpt_pkg::MoveXW-1:0] mvx_q;
  logic signed [ps2mpt_pkg::MoveYW-1:0] mvy_q;
  logic [ps2mpt_pkg::BtnW-1:0] btn_q;

  assign load      = pkt_valid_i && (!out_valid_q || pop_i);
  assign pkt_pop_o = load;
  assign dx        = $signed(pkt_i.dx);
  assign dy_neg    = -$signed({pkt_i.dy[ps2mpt_pkg::MoveXW-1], pkt_i.dy});

  always_comb begin
    lim_x_d     = lim_x_q;
    lim_y_d     = lim_y_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      if (cfg_idx_i == ps2mpt_pkg::CfgIdxWidth) begin
        lim_x_d = eff_limit(cfg_wdata_i);
      end else begin
        lim_y_d = eff_limit(cfg_wdata_i);
      end
      // any size write re-centres both axes
      pos_x_d = lim_x_d[LimW-1:1];
      pos_y_d = lim_y_d[LimW-1:1];
    end else if (load) begin
      pos_x_d     = clamp_move(pos_x_q, SumW'(dx), lim_x_q);
      pos_y_d     = clamp_move(pos_y_q, SumW'(dy_neg), lim_y_q);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_x_q     <= ResetLimX;
      lim_y_q     <= ResetLimY;
      pos_x_q     <= ResetLimX[LimW-1:1];
      pos_y_q     <= ResetLimY[LimW-1:1];
      out_valid_q <= 1'b0;
    end else begin
      lim_x_q     <= lim_x_d;
      lim_y_q     <= lim_y_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_x_q <= pos_x_d;
      cur_y_q <= pos_y_d;
      mvx_q   <= dx;
      mvy_q   <= dy_neg;
      btn_q   <= pkt_i.buttons;
    end
  end

  assign empty_o       = !out_valid_q;
  assign cursor_x_o    = cur_x_q;
  assign cursor_y_o    = cur_y_q;
  assign move_x_o      = mvx_q;
  assign move_y_o      = mvy_q;
  assign button_bits_o = btn_q;

  a_pos_x_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_x_q} < lim_x_q)
    else $error("x position outside limit");

  a_pos_y_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_y_q} < lim_y_q)
    else $error("y position outside limit");

endmodule

@@ rtl/core/ps2_mouse_packet_tracker.sv @@
// Channel   Handshake                  Payload
// input     push_i / full_o            rx_byte_i
// result    empty_o / pop_i            cursor_x_o, cursor_y_o, move_x_o, move_y_o,
//                                      button_bits_o
// config    cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle while full_o is low. A completed packet passes through
// the packet queue and then the output register that the cursor update unit writes
// before it reaches the result ports.
// Reset recentres the cursor in a 640x480 area; no clearing pass is needed.
// full_o rises only while the packet queue is full, which takes a stalled pop_i.
module ps2_mouse_packet_tracker #(
  parameter int CoordBits = 13
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic [7:0]                           rx_byte_i,
  output logic                                 empty_o,
  input  logic                                 pop_i,
  output logic [CoordBits-1:0]                 cursor_x_o,
  output logic [CoordBits-1:0]                 cursor_y_o,
  output logic signed [ps2mpt_pkg::MoveXW-1:0] move_x_o,
  output logic signed [ps2mpt_pkg::MoveYW-1:0] move_y_o,
  output logic [ps2mpt_pkg::BtnW-1:0]          button_bits_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [ps2mpt_pkg::CfgW-1:0]          cfg_wdata_i
);

  ps2mpt_pkg::packet_t front_pkt, back_pkt;
  logic front_push, q_full, q_empty, back_pop;

  assign full_o = q_full;

  ps2mpt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .pkt_push_o (front_push),
    .pkt_o      (front_pkt)
  );

  ps2mpt_fifo #(
    .Depth (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_pkt),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .empty_o (q_empty),
    .data_o  (back_pkt)
  );

  ps2mpt_back #(
    .CoordBits (CoordBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pkt_valid_i   (!q_empty),
    .pkt_i         (back_pkt),
    .pkt_pop_o     (back_pop),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o),
    .move_x_o      (move_x_o),
    .move_y_o      (move_y_o),
    .button_bits_o (button_bits_o)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int CoordW  = 13;
  localparam int LimitNs = 10_000_000;
  localparam int NDir    = 23;

  typedef struct packed {
    logic [CoordW-1:0]                    cx;
    logic [CoordW-1:0]                    cy;
    logic signed [ps2mpt_pkg::MoveXW-1:0] mx;
    logic signed [ps2mpt_pkg::MoveYW-1:0] my;
    logic [ps2mpt_pkg::BtnW-1:0]          btn;
  } cursor_rpt_t;

  typedef struct packed {
    logic [7:0]  b;
    bit          typed;
    cursor_rpt_t rpt;
  } dir_row_t;

  typedef enum int {PopAll, PopHalf, PopSparse, PopHold} pop_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push_i = 1'b0;
  logic                full_o;
  logic [7:0]          rx_byte_i = 8'h00;
  logic                empty_o;
  logic                pop_i = 1'b0;
  logic [CoordW-1:0]   cursor_x_o;
  logic [CoordW-1:0]   cursor_y_o;
  logic signed [ps2mpt_pkg::MoveXW-1:0] move_x_o;
  logic signed [ps2mpt_pkg::MoveYW-1:0] move_y_o;
  logic [ps2mpt_pkg::BtnW-1:0]          button_bits_o;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [ps2mpt_pkg::CfgW-1:0]          cfg_wdata_i = '0;

  ps2_mouse_packet_tracker #(.CoordBits(CoordW)) dut (
    .clk_i, .rst_ni, .push_i, .full_o, .rx_byte_i, .empty_o, .pop_i,
    .cursor_x_o, .cursor_y_o, .move_x_o, .move_y_o, .button_bits_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #6 clk_i = ~clk_i;

  // tracker model state
  ps2mpt_pkg::byte_pos_e       trk_pos;
  logic [7:0]                  trk_hdr;
  logic [7:0]                  trk_xb;
  logic [ps2mpt_pkg::CfgW-1:0] scr_w;
  logic [ps2mpt_pkg::CfgW-1:0] scr_h;
  logic [CoordW-1:0]           trk_px;
  logic [CoordW-1:0]           trk_py;

  cursor_rpt_t pending_rpts[$];
  dir_row_t    dir_tab [NDir];
  int mismatches = 0;
  int bytes_sent = 0;
  int rpts_seen = 0;
  int cfg_writes = 0;
  int pop_cyc = 0;
  pop_mode_e pop_mode = PopAll;
  cursor_rpt_t got_r;
  cursor_rpt_t want_r;

  function automatic int eff_lim(logic [ps2mpt_pkg::CfgW-1:0] s);
    if (s == 0) return 1;
    if (s > (1 << CoordW)) return 1 << CoordW;
    return int'(s);
  endfunction

  function automatic logic [CoordW-1:0] clamp_pos(int p, int lim);
    if (p < 0) p = 0;
    if (p >= lim) p = lim - 1;
    return p[CoordW-1:0];
  endfunction

  function automatic dir_row_t plain(logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.b = b;
    return r;
  endfunction

  function automatic dir_row_t typed(logic [7:0] b, int x, int y, int mx, int my, int btn);
    dir_row_t r;
    r.b = b;
    r.typed = 1'b1;
    r.rpt.cx = x[CoordW-1:0];
    r.rpt.cy = y[CoordW-1:0];
    r.rpt.mx = mx[ps2mpt_pkg::MoveXW-1:0];
    r.rpt.my = my[ps2mpt_pkg::MoveYW-1:0];
    r.rpt.btn = btn[ps2mpt_pkg::BtnW-1:0];
    return r;
  endfunction

  task automatic recentre();
    trk_px = CoordW'(eff_lim(scr_w) / 2);
    trk_py = CoordW'(eff_lim(scr_h) / 2);
  endtask

  task automatic track_byte(input logic [7:0] b, output bit got, output cursor_rpt_t r);
    int dx;
    int dy;
    got = 1'b0;
    r = '0;
    case (trk_pos)
      ps2mpt_pkg::BpHeader: begin
        // resync: a header always has the sync bit set
        if (b[ps2mpt_pkg::HdrSyncBit]) begin
          trk_hdr = b;
          trk_pos = ps2mpt_pkg::BpX;
        end
      end
      ps2mpt_pkg::BpX: begin
        trk_xb = b;
        trk_pos = ps2mpt_pkg::BpY;
      end
      default: begin
        trk_pos = ps2mpt_pkg::BpHeader;
        if (!trk_hdr[ps2mpt_pkg::HdrXOvfBit] && !trk_hdr[ps2mpt_pkg::HdrYOvfBit]) begin
          dx = int'(trk_xb) - (trk_hdr[ps2mpt_pkg::HdrXSignBit] ? 256 : 0);
          dy = -(int'(b) - (trk_hdr[ps2mpt_pkg::HdrYSignBit] ? 256 : 0));
          trk_px = clamp_pos(int'(trk_px) + dx, eff_lim(scr_w));
          trk_py = clamp_pos(int'(trk_py) + dy, eff_lim(scr_h));
          r.cx = trk_px;
          r.cy = trk_py;
          r.mx = dx[ps2mpt_pkg::MoveXW-1:0];
          r.my = dy[ps2mpt_pkg::MoveYW-1:0];
          r.btn = trk_hdr[ps2mpt_pkg::BtnW-1:0];
          got = 1'b1;
        end
      end
    endcase
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic send_byte(input logic [7:0] b, output bit got, output cursor_rpt_t r);
    push_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    bytes_sent++;
    track_byte(b, got, r);
  endtask

  // wait until every report is back, then let any packet in flight land
  task automatic drain();
    while (pending_rpts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [ps2mpt_pkg::CfgW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ps2mpt_pkg::CfgIdxWidth) scr_w = v;
    else scr_h = v;
    recentre();
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_size(input logic [ps2mpt_pkg::CfgW-1:0] w,
                          input logic [ps2mpt_pkg::CfgW-1:0] h);
    cfg_write(ps2mpt_pkg::CfgIdxWidth, w);
    cfg_write(ps2mpt_pkg::CfgIdxHeight, h);
  endtask

  task automatic run_phase(int n);
    logic [7:0] stream[$];
    logic [7:0] hb;
    int burst;
    int gap;
    bit got;
    cursor_rpt_t r;
    // mostly well-formed packets, some stray bytes to break the framing
    while (stream.size() < n) begin
      if ($urandom_range(0, 9) == 0) begin
        stream.push_back(8'($urandom));
      end else begin
        hb = 8'($urandom);
        hb[ps2mpt_pkg::HdrSyncBit] = 1'b1;
        if ($urandom_range(0, 7) != 0) begin
          hb[ps2mpt_pkg::HdrXOvfBit] = 1'b0;
          hb[ps2mpt_pkg::HdrYOvfBit] = 1'b0;
        end
        stream.push_back(hb);
        stream.push_back(8'($urandom));
        stream.push_back(8'($urandom));
      end
    end
    while (stream.size() > 0) begin
      if ($urandom_range(0, 31) == 0) begin
        if (push_i) push_i <= 1'b0;
        @(posedge clk_i);
        while (pending_rpts.size() != 0) @(posedge clk_i);
      end
      burst = $urandom_range(1, 48);
      while (burst > 0 && stream.size() > 0) begin
        send_byte(stream.pop_front(), got, r);
        if (got) pending_rpts.push_back(r);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (push_i) push_i <= 1'b0;
  endtask

  // result side: check each popped transaction, then pick the next pop
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      got_r = '{cursor_x_o, cursor_y_o, move_x_o, move_y_o, button_bits_o};
      rpts_seen++;
      if (pending_rpts.size() == 0) begin
        note_mismatch($sformatf("unexpected report x=%0d y=%0d mx=%0d my=%0d btn=%0d",
                                got_r.cx, got_r.cy, got_r.mx, got_r.my, got_r.btn));
      end else begin
        want_r = pending_rpts.pop_front();
        if (got_r !== want_r)
          note_mismatch($sformatf(
            "expected x=%0d y=%0d mx=%0d my=%0d btn=%0d, got x=%0d y=%0d mx=%0d my=%0d btn=%0d",
            want_r.cx, want_r.cy, want_r.mx, want_r.my, want_r.btn,
            got_r.cx, got_r.cy, got_r.mx, got_r.my, got_r.btn));
      end
    end
    pop_cyc++;
    if (pop_cyc % 97 == 0) pop_mode = pop_mode_e'($urandom_range(0, 3));
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      case (pop_mode)
        PopAll:    pop_i <= 1'b1;
        PopHalf:   pop_i <= 1'($urandom_range(0, 1));
        PopSparse: pop_i <= ($urandom_range(0, 7) == 0);
        default:   pop_i <= 1'b0;
      endcase
    end
  end

  initial begin
    #(LimitNs);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    bit got;
    cursor_rpt_t r;
    trk_pos = ps2mpt_pkg::BpHeader;
    trk_hdr = '0;
    trk_xb = '0;
    scr_w = ps2mpt_pkg::CfgW'(ps2mpt_pkg::ResetWidth);
    scr_h = ps2mpt_pkg::CfgW'(ps2mpt_pkg::ResetHeight);
    recentre();

    // reset area is 640x480, cursor starts at 320,240
    dir_tab = '{
      plain(8'h00),                          // no sync bit, dropped
      plain(8'hF7),                          // every bit but sync, dropped
      plain(8'h08), plain(8'h00), typed(8'h00, 320, 240, 0, 0, 0),
      plain(8'h0F), plain(8'hFF), typed(8'h00, 575, 240, 255, 0, 7),
      plain(8'h38), plain(8'h00), typed(8'h00, 319, 479, -256, 256, 0),
      plain(8'h08), plain(8'h00), typed(8'hFF, 319, 224, 0, -255, 0),
      plain(8'h48), plain(8'h11), plain(8'h22),  // x overflow, discarded
      plain(8'hF8), plain(8'h7F), plain(8'h80),  // both overflows, discarded
      plain(8'h1A), plain(8'hFF), plain(8'h80)   // next byte is a header again
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NDir; i++) begin
      send_byte(dir_tab[i].b, got, r);
      if (dir_tab[i].typed) pending_rpts.push_back(dir_tab[i].rpt);
      else if (got) pending_rpts.push_back(r);
    end
    if (push_i) push_i <= 1'b0;

    cfg_write(ps2mpt_pkg::CfgIdxWidth, 14'd300);
    run_phase(80);
    cfg_write(ps2mpt_pkg::CfgIdxHeight, 14'd200);
    run_phase(80);
    set_size(14'd0, 14'd0);
    run_phase(60);
    set_size(14'd1, 14'd1);
    run_phase(60);
    set_size(14'd2, 14'd3);
    run_phase(80);
    set_size(14'd8192, 14'd8192);
    run_phase(80);
    set_size(14'd8193, 14'd16383);
    run_phase(80);
    set_size(14'd16383, 14'd1);
    run_phase(80);
    set_size(ps2mpt_pkg::CfgW'($urandom_range(1, 1000)),
             ps2mpt_pkg::CfgW'($urandom_range(1, 1000)));
    run_phase(100);
    set_size(ps2mpt_pkg::CfgW'(ps2mpt_pkg::ResetWidth),
             ps2mpt_pkg::CfgW'(ps2mpt_pkg::ResetHeight));
    run_phase(100);

    drain();
    repeat (6) @(posedge clk_i);

    $display("Sent %0d bytes, checked %0d cursor reports, %0d size writes",
             bytes_sent, rpts_seen, cfg_writes);
    $display("Sizes from 0 up to 16383, resync noise and overflow packets included");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching transactions", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
